>>> sv/ppick_pkg.sv
`default_nettype none
package ppick_pkg;

   localparam int IndexBitsDefault = 20;
   localparam int CoordBits        = 32;
   localparam int TolBits          = 31;
   localparam int FracBits         = 16;
   localparam int ProdBits         = 2 * CoordBits;
   localparam int DenBits          = ProdBits - 1;
   localparam int QuotBits         = CoordBits - 1;
   localparam int PreShift         = QuotBits - FracBits;
   localparam int DivSteps         = QuotBits;
   // pre-check stage + one stage per quotient bit + sign/saturate stage
   localparam int DivLatency       = DivSteps + 2;
   localparam int RegIdxBits       = 3;

   typedef enum logic [RegIdxBits-1:0] {
      REG_X_SCALE      = 3'd0,
      REG_Y_SCALE      = 3'd1,
      REG_X_FROM_DEPTH = 3'd2,
      REG_Y_FROM_DEPTH = 3'd3,
      REG_W_FROM_DEPTH = 3'd4,
      REG_CURSOR_X     = 3'd5,
      REG_CURSOR_Y     = 3'd6,
      REG_TOLERANCE    = 3'd7
   } reg_index_type;

   localparam logic signed [CoordBits-1:0] ResetScale   = 32'sh0001_0000;
   localparam logic signed [CoordBits-1:0] ResetWDepth  = 32'shFFFF_0000;
   localparam logic [TolBits-1:0]          ResetTol     = 31'd655;
   localparam logic signed [CoordBits-1:0] SatMax       = 32'sh7FFF_FFFF;
   localparam logic signed [CoordBits-1:0] SatMin       = 32'sh8000_0000;

endpackage
`default_nettype wire

>>> sv/ppick_if.sv
`default_nettype none
interface ppick_req_if #(parameter int IndexBits = ppick_pkg::IndexBitsDefault);
   logic                  valid;
   logic                  ready;
   logic signed [31:0]    pos_x;
   logic signed [31:0]    pos_y;
   logic signed [31:0]    pos_z;
   logic [IndexBits-1:0]  point_number;

   modport source (output valid, pos_x, pos_y, pos_z, point_number, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, point_number, output ready);
endinterface

interface ppick_rsp_if #(parameter int IndexBits = ppick_pkg::IndexBitsDefault);
   logic                  valid;
   logic                  ready;
   logic [IndexBits-1:0]  hit_number;
   logic signed [31:0]    proj_x;
   logic signed [31:0]    proj_y;

   modport source (output valid, hit_number, proj_x, proj_y, input ready);
   modport sink   (input valid, hit_number, proj_x, proj_y, output ready);
endinterface
`default_nettype wire

>>> sv/perspective_point_pick_test_top.sv
`default_nettype none
// Perspective point pick test. Each req item is one point (x, y, z, signed
// Q16.16) and its index; it is projected with w = z*coef_w_from_depth,
// proj = (pos*scale + z*from_depth) / w, held to Q16.16 with truncation and
// saturation, and a rsp item (index, proj_x, proj_y) leaves only when both
// axes lie within pick_tolerance of the cursor. Points with w == 0 never hit.
// Throughput is one item per clock unless the output stalls. The stages to
// the output register are products, sums, magnitudes, then a divider with
// one quotient bit per stage, then the cursor distance. The whole pipeline
// holds only while a finished rsp item waits and rsp ready is low, so
// req ready is "output register empty or being taken". Registers are written
// through csr_we/csr_index/csr_wdata and must only change while no item is
// in flight.
module perspective_point_pick_test_top #(
   parameter int INDEX_BITS = ppick_pkg::IndexBitsDefault
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ppick_req_if.sink                                 req_chan,
   ppick_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [ppick_pkg::RegIdxBits-1:0]     csr_index,
   input  wire logic [ppick_pkg::CoordBits-1:0]      csr_wdata
);
   import ppick_pkg::*;

   // configuration
   logic signed [CoordBits-1:0] cx_scale_ff, cy_scale_ff, cx_depth_ff, cy_depth_ff;
   logic signed [CoordBits-1:0] cw_depth_ff, cursor_x_ff, cursor_y_ff;
   logic [TolBits-1:0]          tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_scale_ff <= ResetScale;
         cy_scale_ff <= ResetScale;
         cx_depth_ff <= '0;
         cy_depth_ff <= '0;
         cw_depth_ff <= ResetWDepth;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         tol_ff      <= ResetTol;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_X_SCALE:      cx_scale_ff <= csr_wdata;
            REG_Y_SCALE:      cy_scale_ff <= csr_wdata;
            REG_X_FROM_DEPTH: cx_depth_ff <= csr_wdata;
            REG_Y_FROM_DEPTH: cy_depth_ff <= csr_wdata;
            REG_W_FROM_DEPTH: cw_depth_ff <= csr_wdata;
            REG_CURSOR_X:     cursor_x_ff <= csr_wdata;
            REG_CURSOR_Y:     cursor_y_ff <= csr_wdata;
            REG_TOLERANCE:    tol_ff      <= csr_wdata[TolBits-1:0];
            default:          tol_ff      <= tol_ff;
         endcase
      end
   end

   // global advance: stall only when a finished item is stuck at the output
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: products
   logic signed [ProdBits-1:0] px_ff, pxz_ff, py_ff, pyz_ff, pw_ff;
   logic                       s1_vld_ff;
   logic [INDEX_BITS-1:0]      s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff     <= req_chan.pos_x * cx_scale_ff;
         pxz_ff    <= req_chan.pos_z * cx_depth_ff;
         py_ff     <= req_chan.pos_y * cy_scale_ff;
         pyz_ff    <= req_chan.pos_z * cy_depth_ff;
         pw_ff     <= req_chan.pos_z * cw_depth_ff;
         s1_idx_ff <= req_chan.point_number;
      end
   end

   // stage 2: numerator sums, |w|
   logic signed [ProdBits:0]   sx_ff, sy_ff;
   logic [ProdBits-1:0]        wabs;
   logic [DenBits-1:0]         wmag_ff, s3_wmag_ff;
   logic                       wneg_ff, s3_wneg_ff, wz_ff, s3_wz_ff;
   logic                       s2_vld_ff, s3_vld_ff;
   logic [INDEX_BITS-1:0]      s2_idx_ff, s3_idx_ff;

   assign wabs = pw_ff[ProdBits-1] ? ProdBits'(-pw_ff) : pw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff     <= {px_ff[ProdBits-1], px_ff} + {pxz_ff[ProdBits-1], pxz_ff};
         sy_ff     <= {py_ff[ProdBits-1], py_ff} + {pyz_ff[ProdBits-1], pyz_ff};
         wmag_ff   <= wabs[DenBits-1:0];
         wneg_ff   <= pw_ff[ProdBits-1];
         wz_ff     <= (pw_ff == '0);
         s2_idx_ff <= s1_idx_ff;
      end
   end

   // stage 3: numerator magnitudes
   logic [ProdBits:0]   xabs, yabs;
   logic [ProdBits-1:0] xmag_ff, ymag_ff;
   logic                xneg_ff, yneg_ff;

   assign xabs = sx_ff[ProdBits] ? (ProdBits+1)'(-sx_ff) : sx_ff;
   assign yabs = sy_ff[ProdBits] ? (ProdBits+1)'(-sy_ff) : sy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xmag_ff    <= xabs[ProdBits-1:0];
         ymag_ff    <= yabs[ProdBits-1:0];
         xneg_ff    <= sx_ff[ProdBits];
         yneg_ff    <= sy_ff[ProdBits];
         s3_wmag_ff <= wmag_ff;
         s3_wneg_ff <= wneg_ff;
         s3_wz_ff   <= wz_ff;
         s3_idx_ff  <= s2_idx_ff;
      end
   end

   // dividers
   logic signed [CoordBits-1:0] quot_x, quot_y;

   ppick_div u_div_x (
      .clock   (clock),
      .adv     (adv),
      .num_neg (xneg_ff),
      .num_mag (xmag_ff),
      .den_neg (s3_wneg_ff),
      .den_mag (s3_wmag_ff),
      .quot    (quot_x)
   );

   ppick_div u_div_y (
      .clock   (clock),
      .adv     (adv),
      .num_neg (yneg_ff),
      .num_mag (ymag_ff),
      .den_neg (s3_wneg_ff),
      .den_mag (s3_wmag_ff),
      .quot    (quot_y)
   );

   // sideband line matching the divider latency
   logic                  sb_vld_ff [DivLatency];
   logic                  sb_wz_ff  [DivLatency];
   logic [INDEX_BITS-1:0] sb_idx_ff [DivLatency];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivLatency; i++) sb_vld_ff[i] <= 1'b0;
      end else if (adv) begin
         sb_vld_ff[0] <= s3_vld_ff;
         for (int i = 1; i < DivLatency; i++) sb_vld_ff[i] <= sb_vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_wz_ff[0]  <= s3_wz_ff;
         sb_idx_ff[0] <= s3_idx_ff;
         for (int i = 1; i < DivLatency; i++) begin
            sb_wz_ff[i]  <= sb_wz_ff[i-1];
            sb_idx_ff[i] <= sb_idx_ff[i-1];
         end
      end
   end

   // distance stage: cursor - proj, exact in 33 bits
   logic signed [CoordBits:0]   dx_ff, dy_ff;
   logic signed [CoordBits-1:0] dist_px_ff, dist_py_ff;
   logic                        dist_vld_ff, dist_wz_ff;
   logic [INDEX_BITS-1:0]       dist_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else if (adv) begin
         dist_vld_ff <= sb_vld_ff[DivLatency-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff       <= {cursor_x_ff[CoordBits-1], cursor_x_ff} - {quot_x[CoordBits-1], quot_x};
         dy_ff       <= {cursor_y_ff[CoordBits-1], cursor_y_ff} - {quot_y[CoordBits-1], quot_y};
         dist_px_ff  <= quot_x;
         dist_py_ff  <= quot_y;
         dist_wz_ff  <= sb_wz_ff[DivLatency-1];
         dist_idx_ff <= sb_idx_ff[DivLatency-1];
      end
   end

   // tolerance test and output register
   logic [CoordBits:0] dx_abs, dy_abs;
   logic               hit;
   logic [INDEX_BITS-1:0]       rsp_idx_ff;
   logic signed [CoordBits-1:0] rsp_px_ff, rsp_py_ff;

   assign dx_abs = dx_ff[CoordBits] ? (CoordBits+1)'(-dx_ff) : dx_ff;
   assign dy_abs = dy_ff[CoordBits] ? (CoordBits+1)'(-dy_ff) : dy_ff;
   assign hit    = dist_vld_ff && !dist_wz_ff
                   && (dx_abs <= {2'b00, tol_ff}) && (dy_abs <= {2'b00, tol_ff});
   assign rsp_valid_in = adv ? hit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff <= dist_idx_ff;
         rsp_px_ff  <= dist_px_ff;
         rsp_py_ff  <= dist_py_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit_number = rsp_idx_ff;
   assign rsp_chan.proj_x     = rsp_px_ff;
   assign rsp_chan.proj_y     = rsp_py_ff;

`ifndef SYNTHESIS
   a_reset_clears_out: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("rsp valid right after reset");

   a_zero_w_no_hit: assert property (@(posedge clock) disable iff (reset)
      (adv && dist_wz_ff) |=> !rsp_valid_ff)
      else $error("item with w == 0 produced a hit");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (dist_vld_ff == $past(dist_vld_ff)) && $stable(sb_vld_ff[0]))
      else $error("pipeline moved during stall");

   a_ready_only_blocked_by_out: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff)
      else $error("input blocked with empty output");
`endif
endmodule
`default_nettype wire

>>> sv/ppick_div.sv
`default_nettype none
// Pipelined restoring divider: (num * 2^16) / den, truncated, saturated to 32 bits.
module ppick_div (
   input  wire logic                                clock,
   input  wire logic                                adv,
   input  wire logic                                num_neg,
   input  wire logic [ppick_pkg::ProdBits-1:0]      num_mag,
   input  wire logic                                den_neg,
   input  wire logic [ppick_pkg::DenBits-1:0]       den_mag,
   output logic signed [ppick_pkg::CoordBits-1:0]   quot
);
   import ppick_pkg::*;

   localparam int CmpBits = ProdBits + PreShift;

   logic                 sat_ff [DivSteps+1];
   logic                 neg_ff [DivSteps+1];
   logic [DenBits-1:0]   den_ff [DivSteps+1];
   logic [DenBits-1:0]   rem_ff [DivSteps+1];
   logic [QuotBits-1:0]  qn_ff  [DivSteps+1];
   logic [DenBits-1:0]   rem_in [DivSteps+1];
   logic [QuotBits-1:0]  qn_in  [DivSteps+1];
   logic signed [CoordBits-1:0] quot_ff;
   logic signed [CoordBits-1:0] quot_in;
   logic                 sat_in;

   // quotient >= 2^31 exactly when num >= den * 2^15
   assign sat_in = {{PreShift{1'b0}}, num_mag} >= {{(CmpBits-DenBits-PreShift){1'b0}},
                   den_mag, {PreShift{1'b0}}};
   assign rem_in[0] = {{(DenBits-ProdBits+PreShift){1'b0}}, num_mag[ProdBits-1:PreShift]};
   assign qn_in[0]  = {num_mag[PreShift-1:0], {FracBits{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff[0] <= sat_in;
         neg_ff[0] <= num_neg ^ den_neg;
         den_ff[0] <= den_mag;
         rem_ff[0] <= rem_in[0];
         qn_ff[0]  <= qn_in[0];
      end
   end

   for (genvar k = 1; k <= DivSteps; k++) begin : g_step
      logic [ProdBits-1:0] trial;
      logic                ge;
      always_comb begin
         trial    = {rem_ff[k-1], qn_ff[k-1][QuotBits-1]};
         ge       = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge ? DenBits'(trial - {1'b0, den_ff[k-1]}) : trial[DenBits-1:0];
         qn_in[k]  = {qn_ff[k-1][QuotBits-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sat_ff[k] <= sat_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            rem_ff[k] <= rem_in[k];
            qn_ff[k]  <= qn_in[k];
         end
      end
   end

   always_comb begin
      priority if (sat_ff[DivSteps]) begin
         quot_in = neg_ff[DivSteps] ? SatMin : SatMax;
      end else if (neg_ff[DivSteps]) begin
         quot_in = -$signed({1'b0, qn_ff[DivSteps]});
      end else begin
         quot_in = $signed({1'b0, qn_ff[DivSteps]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> tb/sv/perspective_point_pick_test_checker.sv
`default_nettype none
module perspective_point_pick_test_checker #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ppick_req_if                                     req,
   ppick_rsp_if                                     rsp,
   input  wire logic                                csr_we,
   input  wire logic [ppick_pkg::RegIdxBits-1:0]    csr_index,
   input  wire logic [ppick_pkg::CoordBits-1:0]     csr_wdata,
   output int                                       mismatches,
   output int                                       hits_pending
);
   import ppick_pkg::*;

   typedef struct packed {
      logic [INDEX_BITS-1:0] number;
      logic signed [31:0]    px;
      logic signed [31:0]    py;
   } hit_type;

   hit_type hits_q[$];
   logic signed [31:0] coef [8];

   // numerator / w to Q16.16, truncated toward zero, saturated
   function automatic logic signed [31:0] divide_q16(logic signed [64:0] num,
                                                     logic signed [63:0] w);
      logic [95:0] nmag, wmag, q;
      logic        nneg, wneg;
      nneg = num < 0;
      wneg = w < 0;
      nmag = nneg ? 96'(-num) : 96'(num);
      wmag = wneg ? 96'(-w) : 96'(w);
      q = (nmag << FracBits) / wmag;
      if (nneg != wneg)
         return (q >= 96'h8000_0000) ? SatMin : -$signed(q[31:0]);
      return (q > 96'h7FFF_FFFF) ? SatMax : $signed(q[31:0]);
   endfunction

   function automatic bit close_to(logic signed [31:0] cur, logic signed [31:0] p);
      logic signed [32:0] d;
      logic [32:0]        m;
      d = 33'(cur) - 33'(p);
      m = d[32] ? 33'(-d) : 33'(d);
      return m <= {2'b0, coef[REG_TOLERANCE][30:0]};
   endfunction

   always @(posedge clock) begin
      logic signed [63:0] w;
      logic signed [64:0] nx, ny;
      hit_type            h, got;
      if (reset) begin
         coef[REG_X_SCALE]      <= ResetScale;
         coef[REG_Y_SCALE]      <= ResetScale;
         coef[REG_X_FROM_DEPTH] <= '0;
         coef[REG_Y_FROM_DEPTH] <= '0;
         coef[REG_W_FROM_DEPTH] <= ResetWDepth;
         coef[REG_CURSOR_X]     <= '0;
         coef[REG_CURSOR_Y]     <= '0;
         coef[REG_TOLERANCE]    <= {1'b0, ResetTol};
         hits_q.delete();
         mismatches <= 0;
         hits_pending <= 0;
      end else begin
         if (csr_we)
            coef[csr_index] <= (csr_index == REG_TOLERANCE) ?
                               {1'b0, csr_wdata[30:0]} : csr_wdata;
         if (req.valid && req.ready) begin
            w = 64'(req.pos_z) * 64'(coef[REG_W_FROM_DEPTH]);
            if (w != 0) begin
               nx = 65'(req.pos_x) * 65'(coef[REG_X_SCALE])
                  + 65'(req.pos_z) * 65'(coef[REG_X_FROM_DEPTH]);
               ny = 65'(req.pos_y) * 65'(coef[REG_Y_SCALE])
                  + 65'(req.pos_z) * 65'(coef[REG_Y_FROM_DEPTH]);
               h.number = req.point_number;
               h.px = divide_q16(nx, w);
               h.py = divide_q16(ny, w);
               if (close_to(coef[REG_CURSOR_X], h.px) && close_to(coef[REG_CURSOR_Y], h.py))
                  hits_q.push_back(h);
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (hits_q.size() == 0) begin
               $error("unexpected hit item: number %0d", rsp.hit_number);
               mismatches <= mismatches + 1;
            end else begin
               h = hits_q.pop_front();
               got = {rsp.hit_number, rsp.proj_x, rsp.proj_y};
               if (got != h) begin
                  if (got.number != h.number)
                     $error("hit_number: expected %0d, got %0d", h.number, got.number);
                  if (got.px != h.px)
                     $error("proj_x: expected %0d, got %0d", h.px, got.px);
                  if (got.py != h.py)
                     $error("proj_y: expected %0d, got %0d", h.py, got.py);
                  mismatches <= mismatches + 1;
               end
            end
         end
         hits_pending <= hits_q.size();
      end
   end
endmodule
`default_nettype wire

>>> tb/sv/perspective_point_pick_test_top_tb.sv
`default_nettype none
module perspective_point_pick_test_top_tb;
   import ppick_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainWait  = 45;     // longer than the pipeline depth

   logic clock;
   logic reset;
   logic csr_we;
   logic [RegIdxBits-1:0] csr_index;
   logic [CoordBits-1:0]  csr_wdata;
   int   mismatches, hits_pending;
   int   cycles;

   // shadow of the register file, used only to aim points at the cursor
   logic signed [31:0] shadow [8];

   // idling control
   bit calm;
   int hold_reqs, hold_seen, hold_left;

   ppick_req_if #(20) req_chan ();
   ppick_rsp_if #(20) rsp_chan ();

   perspective_point_pick_test_top #(.INDEX_BITS(20)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   perspective_point_pick_test_checker #(.INDEX_BITS(20)) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .hits_pending (hits_pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // rsp side: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= 300;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
      end
   end

   // write enable stays high across back-to-back writes; callers drop it after
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      shadow[idx] = (idx == REG_TOLERANCE) ? {1'b0, value[30:0]} : value;
      @(posedge clock);
   endtask

   // drain everything that may be in flight before touching registers
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (hits_pending != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // one req item; valid stays high into the next item unless we idle
   task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [19:0] n);
      while (!calm && $urandom_range(99) < 26) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.pos_x        <= x;
      req_chan.pos_y        <= y;
      req_chan.pos_z        <= z;
      req_chan.point_number <= n;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // solve for a coordinate aimed within tolerance of the cursor; random if scale is zero or the result overflows
   function automatic logic [31:0] aim(logic signed [31:0] scale, logic signed [31:0] depth,
                                       logic signed [31:0] cur, logic signed [31:0] z);
      logic signed [127:0] t, v, lim;
      lim = (shadow[REG_TOLERANCE] > 4096) ? 4096 : shadow[REG_TOLERANCE];
      t = 128'(cur) + $signed(128'($urandom_range(0, 2 * lim))) - lim;
      if (scale == 0)
         return $urandom;
      v = (t * 128'(z) * 128'(shadow[REG_W_FROM_DEPTH])) >>> 16;
      v = (v - 128'(z) * 128'(depth)) / 128'(scale);
      if (v > 128'sh7FFF_FFFF || v < -128'sh8000_0000)
         return $urandom;
      return v[31:0];
   endfunction

   task automatic random_point(int aimed_pct);
      logic [31:0] z;
      z = ($urandom_range(1) ? $urandom : $urandom_range(1, 32'h0004_0000));
      if ($urandom_range(1)) z = -z;
      if ($urandom_range(99) < aimed_pct)
         send(aim(shadow[REG_X_SCALE], shadow[REG_X_FROM_DEPTH], shadow[REG_CURSOR_X], z),
              aim(shadow[REG_Y_SCALE], shadow[REG_Y_FROM_DEPTH], shadow[REG_CURSOR_Y], z),
              z, $urandom_range(0, 20'hFFFFF));
      else
         send($urandom, $urandom, $urandom, $urandom_range(0, 20'hFFFFF));
   endtask

   task automatic random_config(logic [30:0] tol);
      write_reg(REG_X_SCALE,      $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      write_reg(REG_Y_SCALE,      $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      write_reg(REG_X_FROM_DEPTH, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_Y_FROM_DEPTH, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_W_FROM_DEPTH, $urandom_range(1, 32'h0002_0000) * ($urandom_range(1) ? 1 : -1));
      write_reg(REG_CURSOR_X,     $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_CURSOR_Y,     $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_TOLERANCE,    {1'b0, tol});
      csr_we <= 1'b0;
   endtask

   initial begin
      cycles = 0;
      calm = 0;
      hold_reqs = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      req_chan.point_number <= '0;
      shadow[REG_X_SCALE]      = ResetScale;
      shadow[REG_Y_SCALE]      = ResetScale;
      shadow[REG_X_FROM_DEPTH] = 0;
      shadow[REG_Y_FROM_DEPTH] = 0;
      shadow[REG_W_FROM_DEPTH] = ResetWDepth;
      shadow[REG_CURSOR_X]     = 0;
      shadow[REG_CURSOR_Y]     = 0;
      shadow[REG_TOLERANCE]    = {1'b0, ResetTol};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset registers: proj = -pos/z, tolerance 655
      send(32'h0, 32'h0, 32'h0, 20'h0);                   // z = 0 -> w = 0, no hit
      send(32'h0, 32'h0, 32'h0001_0000, 20'hFFFFF);       // dead center
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 20'h1);   // saturates low
      send(32'h8000_0000, 32'h8000_0000, 32'h1, 20'h2);   // saturates high
      send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h3);
      send(32'd655, -32'sd655, 32'hFFFF_0000, 20'h4);     // exactly on tolerance
      send(32'd656, 32'h0, 32'hFFFF_0000, 20'h5);         // one past tolerance
      send(32'h0, -32'sd656, 32'hFFFF_0000, 20'h6);
      send(32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 20'h7);   // tiny quotients truncate
      send(32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 20'h8);
      settle();

      // extremes everywhere, tolerance at its top so saturated values can hit
      write_reg(REG_X_SCALE,      32'h7FFF_FFFF);
      write_reg(REG_Y_SCALE,      32'h8000_0000);
      write_reg(REG_X_FROM_DEPTH, 32'h8000_0000);
      write_reg(REG_Y_FROM_DEPTH, 32'h7FFF_FFFF);
      write_reg(REG_W_FROM_DEPTH, 32'h8000_0000);
      write_reg(REG_CURSOR_X,     32'h7FFF_FFFF);
      write_reg(REG_CURSOR_Y,     32'h8000_0000);
      write_reg(REG_TOLERANCE,    32'h7FFF_FFFF);
      csr_we <= 1'b0;
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h0);
      send(32'h8000_0000, 32'h8000_0000, 32'h1, 20'h1);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'h2);
      repeat (120) random_point(0);
      settle();

      // zero depth factor: nothing can hit
      write_reg(REG_W_FROM_DEPTH, 32'h0);
      csr_we <= 1'b0;
      repeat (20) random_point(0);
      settle();

      // tolerance zero: only exact landings hit
      random_config(31'd0);
      repeat (60) random_point(80);
      settle();

      // mixed random settings, long hold-off, one full pause, one calm stretch
      for (int phase = 0; phase < 5; phase++) begin
         random_config($urandom_range(0, 31'h4000));
         for (int i = 0; i < 190; i++) begin
            calm = (phase == 3 && i >= 40 && i < 140);
            if (phase == 1 && i == 30)
               hold_reqs++;
            if (phase == 2 && i == 95) begin
               req_chan.valid <= 1'b0;
               @(posedge clock);
               while (hits_pending != 0)
                  @(posedge clock);
            end
            random_point(65);
         end
         calm = 0;
         settle();
      end

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
